// File: hw/rtl/srg_pkg.sv
// Shared constants and types for the SCPI status register groups.
package srg_pkg;

  localparam int NUM_GROUPS    = 3;
  localparam int GRP_AW        = $clog2(NUM_GROUPS);
  localparam int NUM_SLOTS     = 5;
  localparam int BUS_W         = 16;
  localparam int REG_WIDTH_DEF = 16;
  localparam int EXT_W         = 32;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    SEL_ENABLE     = 3'd0,
    SEL_EVENT      = 3'd1,
    SEL_NEG_FILTER = 3'd2,
    SEL_POS_FILTER = 3'd3,
    SEL_CONDITION  = 3'd4
  } sel_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_t;

endpackage

// File: hw/rtl/srg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module srg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/scpi_status_register_groups_top.sv
// Three SCPI status register groups held as one packed entry per group in a RAM.
// Each access reads its group entry from the RAM, then modifies and writes it back
// with the output register loaded.
// Start is ignored while busy: each access finishes its RAM read and write back first.
// Reset: synchronous, active low; per-group valid bits make untouched groups read zero.
// The receiver cannot stall: out_valid is high for exactly one cycle per access.
module scpi_status_register_groups_top
  import srg_pkg::*;
#(
  parameter int REG_WIDTH = REG_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  logic [1:0]       in_group_select,
  input  logic [2:0]       in_reg_select,
  input  logic [BUS_W-1:0] in_write_data,
  output logic             out_valid,
  output logic [BUS_W-1:0] out_read_data,
  output logic             out_access_error
);

  localparam int ENTRY_W = NUM_SLOTS * REG_WIDTH;

  state_t state_r, state_nxt;
  logic   accept;

  // captured transaction
  logic             req_r;
  logic [1:0]       grp_r;
  logic [2:0]       sel_r;
  logic [BUS_W-1:0] wd_r;

  logic [NUM_GROUPS-1:0] valid_r, valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BUS_W-1:0]      out_data_r, out_data_nxt;
  logic                  out_err_r, out_err_nxt;

  logic [ENTRY_W-1:0]   rdata, entry, entry_new;
  logic                 we;
  logic [GRP_AW-1:0]    gidx;
  logic                 bad;
  logic [REG_WIDTH-1:0] wdat, old_cond, rose, fell, result;
  logic [EXT_W-1:0]     wd_ext, res_ext;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r == ST_BUSY);
  assign gidx   = grp_r[GRP_AW-1:0];

  srg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_GROUPS),
    .AW    (GRP_AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (gidx),
    .wdata (entry_new),
    .raddr (in_group_select[GRP_AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    bad      = (32'(grp_r) >= NUM_GROUPS) ||
               !(sel_r inside {SEL_ENABLE, SEL_EVENT, SEL_NEG_FILTER,
                               SEL_POS_FILTER, SEL_CONDITION});
    entry    = valid_r[gidx] ? rdata : '0;
    wd_ext   = {{(EXT_W-BUS_W){1'b0}}, wd_r};
    wdat     = wd_ext[REG_WIDTH-1:0];
    old_cond = entry[SEL_CONDITION*REG_WIDTH +: REG_WIDTH];
    rose     = ~old_cond & wdat & entry[SEL_POS_FILTER*REG_WIDTH +: REG_WIDTH];
    fell     = old_cond & ~wdat & entry[SEL_NEG_FILTER*REG_WIDTH +: REG_WIDTH];
    entry_new = entry;
    entry_new[sel_r*REG_WIDTH +: REG_WIDTH] = wdat;
    if (sel_r == SEL_CONDITION) begin
      entry_new[SEL_EVENT*REG_WIDTH +: REG_WIDTH] =
        entry[SEL_EVENT*REG_WIDTH +: REG_WIDTH] | rose | fell;
    end
    result  = (req_r == REQ_WRITE) ? wdat : entry[sel_r*REG_WIDTH +: REG_WIDTH];
    res_ext = EXT_W'(result);
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    out_err_nxt   = out_err_r;
    we            = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_err_nxt   = bad;
        out_data_nxt  = bad ? '0 : res_ext[BUS_W-1:0];
        if (!bad && req_r == REQ_WRITE) begin
          we              = 1'b1;
          valid_nxt[gidx] = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      grp_r <= in_group_select;
      sel_r <= in_reg_select;
      wd_r  <= in_write_data;
    end
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_data_r;
  assign out_access_error = out_err_r;

endmodule

// File: hw/rtl/srg_checker.sv
// Port-level checker for the status register groups, bound to the top level.
module srg_checker
  import srg_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [BUS_W-1:0] out_read_data,
  input logic             out_access_error
);

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("no result after busy cycle");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe repeated");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_access_error |-> out_read_data == '0)
    else $error("error result carries nonzero data");

endmodule

bind scpi_status_register_groups_top srg_checker u_srg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_read_data    (out_read_data),
  .out_access_error (out_access_error)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the SCPI status register groups: directed table plus random accesses.
module tb_top;
  import srg_pkg::*;

  localparam logic [1:0] GRP_QUES = 2'd0;
  localparam logic [1:0] GRP_OPER = 2'd1;
  localparam logic [1:0] GRP_CSUM = 2'd2;
  localparam logic [1:0] GRP_BAD  = 2'd3;

  localparam logic [2:0] SEL_RSVD_5 = 3'd5;
  localparam logic [2:0] SEL_RSVD_6 = 3'd6;
  localparam logic [2:0] SEL_RSVD_7 = 3'd7;

  localparam int N_DIRECTED   = 26;
  localparam int PHASE_ITEMS  = 112;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [BUS_W-1:0] read_data;
    logic             access_error;
  } access_result_t;

  typedef struct {
    req_t             req;
    logic [1:0]       grp;
    logic [2:0]       sel;
    logic [BUS_W-1:0] data;
    bit               typed;
    logic [BUS_W-1:0] exp_data;
    logic             exp_err;
  } bus_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_req_type;
  logic [1:0]       in_group_select;
  logic [2:0]       in_reg_select;
  logic [BUS_W-1:0] in_write_data;
  logic             out_valid;
  logic [BUS_W-1:0] out_read_data;
  logic             out_access_error;

  // shadow copy of the register file, updated at each accepted transaction
  logic [BUS_W-1:0] grp_enable     [NUM_GROUPS];
  logic [BUS_W-1:0] grp_event      [NUM_GROUPS];
  logic [BUS_W-1:0] grp_neg_filter [NUM_GROUPS];
  logic [BUS_W-1:0] grp_pos_filter [NUM_GROUPS];
  logic [BUS_W-1:0] grp_condition  [NUM_GROUPS];

  access_result_t pending_results[$];
  access_result_t oldest_result;
  int             fail_count = 0;

  bus_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{REQ_READ,  GRP_QUES, SEL_ENABLE,     16'h0000, 1'b1, 16'h0000, 1'b0},
    '{REQ_READ,  GRP_CSUM, SEL_CONDITION,  16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{REQ_READ,  GRP_BAD,  SEL_ENABLE,     16'h0000, 1'b1, 16'h0000, 1'b1},
    '{REQ_WRITE, GRP_BAD,  SEL_EVENT,      16'hFFFF, 1'b1, 16'h0000, 1'b1},
    '{REQ_READ,  GRP_QUES, SEL_RSVD_5,     16'h0000, 1'b1, 16'h0000, 1'b1},
    '{REQ_WRITE, GRP_OPER, SEL_RSVD_7,     16'hFFFF, 1'b1, 16'h0000, 1'b1},
    '{REQ_WRITE, GRP_QUES, SEL_RSVD_6,     16'h1234, 1'b1, 16'h0000, 1'b1},
    '{REQ_WRITE, GRP_QUES, SEL_POS_FILTER, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    '{REQ_WRITE, GRP_QUES, SEL_NEG_FILTER, 16'h00FF, 1'b1, 16'h00FF, 1'b0},
    '{REQ_WRITE, GRP_QUES, SEL_CONDITION,  16'hA5A5, 1'b1, 16'hA5A5, 1'b0},
    '{REQ_READ,  GRP_QUES, SEL_EVENT,      16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_READ,  GRP_QUES, SEL_EVENT,      16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{REQ_WRITE, GRP_QUES, SEL_CONDITION,  16'hA5A5, 1'b1, 16'hA5A5, 1'b0},
    '{REQ_READ,  GRP_QUES, SEL_EVENT,      16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_WRITE, GRP_QUES, SEL_CONDITION,  16'h0000, 1'b1, 16'h0000, 1'b0},
    '{REQ_READ,  GRP_QUES, SEL_EVENT,      16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_WRITE, GRP_OPER, SEL_ENABLE,     16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    '{REQ_READ,  GRP_OPER, SEL_ENABLE,     16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_WRITE, GRP_CSUM, SEL_NEG_FILTER, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    '{REQ_WRITE, GRP_CSUM, SEL_CONDITION,  16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    '{REQ_WRITE, GRP_CSUM, SEL_CONDITION,  16'h0000, 1'b1, 16'h0000, 1'b0},
    '{REQ_READ,  GRP_CSUM, SEL_EVENT,      16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_WRITE, GRP_OPER, SEL_EVENT,      16'h8001, 1'b1, 16'h8001, 1'b0},
    '{REQ_READ,  GRP_OPER, SEL_EVENT,      16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_READ,  GRP_CSUM, SEL_NEG_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_READ,  GRP_BAD,  SEL_RSVD_7,     16'hFFFF, 1'b1, 16'h0000, 1'b1}
  };

  int idle_plan [4] = '{0, 78, 0, 15};

  scpi_status_register_groups_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_group_select  (in_group_select),
    .in_reg_select    (in_reg_select),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_read_data    (out_read_data),
    .out_access_error (out_access_error)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Applies one bus access to the shadow registers and returns what the bus should see.
  function automatic access_result_t apply_access(input req_t rt, input logic [1:0] grp,
                                                  input logic [2:0] sel,
                                                  input logic [BUS_W-1:0] wdata);
    access_result_t res;
    logic [BUS_W-1:0] rising;
    logic [BUS_W-1:0] falling;
    res = '0;
    if (grp >= NUM_GROUPS || sel > SEL_CONDITION) begin
      res.access_error = 1'b1;
      return res;
    end
    if (rt == REQ_WRITE) begin
      case (sel)
        SEL_ENABLE:     grp_enable[grp] = wdata;
        SEL_EVENT:      grp_event[grp] = wdata;
        SEL_NEG_FILTER: grp_neg_filter[grp] = wdata;
        SEL_POS_FILTER: grp_pos_filter[grp] = wdata;
        SEL_CONDITION: begin
          rising  = ~grp_condition[grp] & wdata & grp_pos_filter[grp];
          falling = grp_condition[grp] & ~wdata & grp_neg_filter[grp];
          grp_event[grp]     = grp_event[grp] | rising | falling;
          grp_condition[grp] = wdata;
        end
        default: ;
      endcase
      res.read_data = wdata;
    end else begin
      case (sel)
        SEL_ENABLE:     res.read_data = grp_enable[grp];
        SEL_EVENT:      res.read_data = grp_event[grp];
        SEL_NEG_FILTER: res.read_data = grp_neg_filter[grp];
        SEL_POS_FILTER: res.read_data = grp_pos_filter[grp];
        SEL_CONDITION:  res.read_data = grp_condition[grp];
        default: ;
      endcase
    end
    return res;
  endfunction

  // Holds the transaction on the bus until accepted; queues the typed or predicted result.
  task automatic send_access(input req_t rt, input logic [1:0] grp, input logic [2:0] sel,
                             input logic [BUS_W-1:0] wdata, input bit use_typed,
                             input access_result_t typed);
    access_result_t predicted;
    @(negedge clk);
    start           <= 1'b1;
    in_req_type     <= rt;
    in_group_select <= grp;
    in_reg_select   <= sel;
    in_write_data   <= wdata;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_access(rt, grp, sel, wdata);
    pending_results.push_back(use_typed ? typed : predicted);
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_random(input int idle_pct);
    req_t             rt;
    logic [1:0]       grp;
    logic [2:0]       sel;
    logic [BUS_W-1:0] wdata;
    int               pick;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    pick = $urandom_range(99);
    rt   = req_t'($urandom_range(1));
    grp  = (pick < 6) ? GRP_BAD : 2'($urandom_range(NUM_GROUPS - 1));
    if (pick >= 6 && pick < 12)
      sel = 3'($urandom_range(7, 5));
    else if ($urandom_range(99) < 40)
      sel = SEL_CONDITION;
    else
      sel = 3'($urandom_range(3));
    // bias condition data toward small and full changes of the current value
    case ($urandom_range(3))
      0: wdata = 16'($urandom);
      1: wdata = (grp < NUM_GROUPS) ? grp_condition[grp] ^ (16'h1 << $urandom_range(15))
                                    : 16'($urandom);
      2: wdata = (grp < NUM_GROUPS) ? ~grp_condition[grp] : 16'($urandom);
      default: wdata = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
    send_access(rt, grp, sel, wdata, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTED)
          $display("unexpected transaction: read_data=%h access_error=%b",
                   out_read_data, out_access_error);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_read_data !== oldest_result.read_data ||
            out_access_error !== oldest_result.access_error) begin
          fail_count++;
          if (fail_count <= MAX_REPORTED)
            $display("mismatch: read_data exp %h got %h, access_error exp %b got %b",
                     oldest_result.read_data, out_read_data,
                     oldest_result.access_error, out_access_error);
        end
      end
    end
  end

  initial begin
    access_result_t typed;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req_type     = REQ_READ;
    in_group_select = GRP_QUES;
    in_reg_select   = SEL_ENABLE;
    in_write_data   = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_enable[g]     = '0;
      grp_event[g]      = '0;
      grp_neg_filter[g] = '0;
      grp_pos_filter[g] = '0;
      grp_condition[g]  = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      typed.read_data    = directed_rows[i].exp_data;
      typed.access_error = directed_rows[i].exp_err;
      send_access(directed_rows[i].req, directed_rows[i].grp, directed_rows[i].sel,
                  directed_rows[i].data, directed_rows[i].typed, typed);
    end
    pause_until_drained();

    foreach (idle_plan[p]) begin
      repeat (PHASE_ITEMS) send_random(idle_plan[p]);
      pause_until_drained();
    end

    repeat (6) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0d expected transactions never arrived", pending_results.size());
    end
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/srg_pkg.sv
hw/rtl/srg_ram.sv
hw/rtl/scpi_status_register_groups_top.sv
hw/rtl/srg_checker.sv
tb/sv/tb_top.sv
